[hw/rtl/sapq_pkg.sv]
// Shared constants and widths for the sorted-array priority queue.
`timescale 1ns / 1ps
`default_nettype none
package sapq_pkg;

	localparam int CAPACITY = 8;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 4;
	localparam int STATUS_W = 2;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	// output tdata: removed_value, count, head_value, zero fill to whole bytes
	localparam int OUT_BITS   = VALUE_W + COUNT_W + VALUE_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_DELETE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

endpackage
`default_nettype wire

[hw/rtl/sorted_array_priority_queue.sv]
// Sorted-array priority queue: entries in a registered-read RAM, sequenced insert/delete.
// A refused request goes from start to done. A delete moves the count - 1 entries behind
// the head, each with a read step and a compare-and-write step; an insert so moves each
// entry not smaller than the value, then writes the value in a read step at the head,
// else in a compare step. One request at a time; each entry move is a read, then a write.
// Reset: arst_n clears count, state and output valid; RAM contents undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module sorted_array_priority_queue (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [sapq_pkg::VALUE_W-1:0]     s_tdata,  // [31:0] value
	input  wire logic [0:0]                       s_tuser,  // [0] kind
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [sapq_pkg::OUT_DATA_W-1:0]       m_tdata,  // [31:0] removed_value,
	                                                        // [35:32] count,
	                                                        // [67:36] head_value, [71:68] zero
	output logic [sapq_pkg::STATUS_W-1:0]         m_tuser   // [1:0] status
);
	import sapq_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_START   = 7'b0000010,
		S_INS_RD  = 7'b0000100,
		S_INS_CMP = 7'b0001000,
		S_DEL_RD  = 7'b0010000,
		S_DEL_CMP = 7'b0100000,
		S_DONE    = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	logic                 kind_q;
	logic [VALUE_W-1:0]   value_q;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [IDX_W-1:0]     idx_q, idx_d;
	logic [VALUE_W-1:0]   head_q, head_d;
	logic [VALUE_W-1:0]   removed_q, removed_d;
	logic [STATUS_W-1:0]  status_q, status_d;

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [VALUE_W-1:0]   out_removed_q;
	logic [COUNT_W-1:0]   out_count_q;
	logic [VALUE_W-1:0]   out_head_q;
	logic                 out_free;
	logic                 out_load;

	// entry RAM: one write and one registered read per cycle
	logic [VALUE_W-1:0]   mem [CAPACITY];
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [VALUE_W-1:0]   mem_wdata;
	logic [IDX_W-1:0]     mem_raddr;
	logic [VALUE_W-1:0]   mem_rdata_q;

	logic [CNT_W-1:0]     idx_next;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		mem_rdata_q <= mem[mem_raddr];
	end

	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign out_load = (state_q == S_DONE) && out_free;
	assign idx_next = CNT_W'(idx_q) + CNT_W'(1);

	// A shift reads the neighbor in its read step, then writes the slot the previous
	// step freed in its compare step.
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		head_d    = head_q;
		removed_d = removed_q;
		status_d  = status_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = value_q;
		mem_raddr = idx_q;

		case (state_q)
			S_IDLE: begin
				if (s_tvalid)
					state_d = S_START;
			end
			S_START: begin
				removed_d = '0;
				status_d  = ST_OK;
				if (kind_q == KIND_INSERT) begin
					if (cnt_q == CNT_W'(CAPACITY)) begin
						status_d = ST_OVERFLOW;
						state_d  = S_DONE;
					end else begin
						idx_d   = cnt_q[IDX_W-1:0];
						state_d = S_INS_RD;
					end
				end else begin
					if (cnt_q == '0) begin
						status_d = ST_EMPTY;
						state_d  = S_DONE;
					end else begin
						removed_d = head_q;
						cnt_d     = cnt_q - CNT_W'(1);
						idx_d     = '0;
						state_d   = (cnt_q == CNT_W'(1)) ? S_DONE : S_DEL_RD;
					end
				end
			end
			S_INS_RD: begin
				if (idx_q == '0) begin
					// value becomes the new head
					mem_we  = 1'b1;
					head_d  = value_q;
					cnt_d   = cnt_q + CNT_W'(1);
					state_d = S_DONE;
				end else begin
					mem_raddr = idx_q - IDX_W'(1);
					state_d   = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				mem_we = 1'b1;
				// equal entries move up so the new value lands in front of them
				if ($signed(mem_rdata_q) >= $signed(value_q)) begin
					mem_wdata = mem_rdata_q;
					idx_d     = idx_q - IDX_W'(1);
					state_d   = S_INS_RD;
				end else begin
					cnt_d   = cnt_q + CNT_W'(1);
					state_d = S_DONE;
				end
			end
			S_DEL_RD: begin
				mem_raddr = idx_next[IDX_W-1:0];
				state_d   = S_DEL_CMP;
			end
			S_DEL_CMP: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata_q;
				if (idx_q == '0)
					head_d = mem_rdata_q;
				if (idx_next < cnt_q) begin
					idx_d   = idx_next[IDX_W-1:0];
					state_d = S_DEL_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		idx_q     <= idx_d;
		head_q    <= head_d;
		removed_q <= removed_d;
		status_q  <= status_d;
		if (s_tvalid && s_tready) begin
			kind_q  <= s_tuser[0];
			value_q <= s_tdata;
		end
		if (out_load) begin
			out_status_q  <= status_q;
			out_removed_q <= removed_q;
			out_count_q   <= COUNT_W'(cnt_q);
			out_head_q    <= (cnt_q == '0) ? '0 : head_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {(OUT_DATA_W - OUT_BITS)'(0), out_head_q, out_count_q, out_removed_q};

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result loaded outside done step");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q == ST_EMPTY |-> out_count_q == '0 && out_head_q == '0
			&& out_removed_q == '0)
		else $error("empty result carries data");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> CNT_W'(mem_waddr) <= cnt_q)
		else $error("RAM write beyond filled region");
`endif

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for the sorted-array priority queue.
`timescale 1ns / 1ps

class sorted_queue_tracker;
	typedef struct {
		logic [sapq_pkg::STATUS_W-1:0] status;
		logic signed [31:0]            removed;
		logic [sapq_pkg::COUNT_W-1:0]  count;
		logic signed [31:0]            head;
	} queue_result_t;

	logic signed [31:0] slots[sapq_pkg::CAPACITY];
	int                 fill;
	queue_result_t      pending_results[$];
	int                 errors;

	// update the local copy of the queue and queue up the result it must report
	function void note_request(logic kind, logic signed [31:0] value);
		queue_result_t r;
		int            pos;
		r.status  = sapq_pkg::ST_OK;
		r.removed = '0;
		if (kind == sapq_pkg::KIND_INSERT) begin
			if (fill >= sapq_pkg::CAPACITY) begin
				r.status = sapq_pkg::ST_OVERFLOW;
			end else begin
				pos = 0;
				// new value lands in front of equal entries
				while (pos < fill && slots[pos] < value)
					pos++;
				for (int i = fill; i > pos; i--)
					slots[i] = slots[i-1];
				slots[pos] = value;
				fill++;
			end
		end else begin
			if (fill == 0) begin
				r.status = sapq_pkg::ST_EMPTY;
			end else begin
				r.removed = slots[0];
				for (int i = 0; i + 1 < fill; i++)
					slots[i] = slots[i+1];
				fill--;
			end
		end
		r.count = fill[sapq_pkg::COUNT_W-1:0];
		r.head  = (fill > 0) ? slots[0] : '0;
		pending_results.push_back(r);
	endfunction

	function void check_result(logic [sapq_pkg::STATUS_W-1:0] status,
	                           logic [sapq_pkg::OUT_DATA_W-1:0] data);
		queue_result_t e;
		logic [31:0]   got_removed;
		logic [3:0]    got_count;
		logic [31:0]   got_head;
		got_removed = data[31:0];
		got_count   = data[35:32];
		got_head    = data[67:36];
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result status=%h data=%h", $time, status, data);
			errors++;
			return;
		end
		e = pending_results.pop_front();
		if (status !== e.status) begin
			$display("%0t: status expected %h actual %h", $time, e.status, status);
			errors++;
		end
		if (got_removed !== e.removed) begin
			$display("%0t: removed_value expected %h actual %h", $time, e.removed,
			         got_removed);
			errors++;
		end
		if (got_count !== e.count) begin
			$display("%0t: count expected %h actual %h", $time, e.count, got_count);
			errors++;
		end
		if (got_head !== e.head) begin
			$display("%0t: head_value expected %h actual %h", $time, e.head, got_head);
			errors++;
		end
	endfunction

	function int pending();
		return pending_results.size();
	endfunction
endclass

module tb;
	localparam int RANDOM_REQUESTS = 1330;
	localparam int STALL_LIMIT     = 3000;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	logic [sapq_pkg::VALUE_W-1:0]      s_tdata = '0;
	logic [0:0]                        s_tuser = 1'b0;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [sapq_pkg::OUT_DATA_W-1:0]   m_tdata;
	logic [sapq_pkg::STATUS_W-1:0]     m_tuser;

	sorted_queue_tracker tracker;
	bit                  no_idle = 1'b0;
	int                  idle_cycles = 0;

	sorted_array_priority_queue u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [31:0] pick_value(int small_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < small_pct)
			return 32'($signed($urandom_range(0, 6)) - 3);
		if (r < small_pct + 10) begin
			case ($urandom_range(0, 3))
				0: return 32'h7fff_ffff;
				1: return 32'h8000_0000;
				2: return 32'h0000_0000;
				default: return 32'hffff_ffff;
			endcase
		end
		return $urandom();
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_request(input logic kind, input logic [31:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		tracker.note_request(kind, value);
		@(negedge clk);
	endtask

	task automatic run_directed();
		send_request(sapq_pkg::KIND_DELETE, 32'h0);
		send_request(sapq_pkg::KIND_INSERT, 32'h7fff_ffff);
		send_request(sapq_pkg::KIND_INSERT, 32'h8000_0000);
		send_request(sapq_pkg::KIND_INSERT, 32'h0000_0000);
		send_request(sapq_pkg::KIND_INSERT, 32'hffff_ffff);
		send_request(sapq_pkg::KIND_INSERT, 32'd5);
		send_request(sapq_pkg::KIND_INSERT, 32'd5);
		send_request(sapq_pkg::KIND_INSERT, 32'd5);
		send_request(sapq_pkg::KIND_INSERT, 32'h8000_0000);
		// queue full here
		send_request(sapq_pkg::KIND_INSERT, 32'd1);
		repeat (sapq_pkg::CAPACITY)
			send_request(sapq_pkg::KIND_DELETE, $urandom());
		send_request(sapq_pkg::KIND_DELETE, 32'hffff_ffff);
	endtask

	task automatic run_random();
		int insert_pct;
		int small_pct;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 150 == 0) begin
				case ($urandom_range(0, 2))
					0: insert_pct = 25;
					1: insert_pct = 50;
					default: insert_pct = 80;
				endcase
				small_pct = $urandom_range(0, 1) ? 40 : 5;
				no_idle   = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 99) < insert_pct)
				send_request(sapq_pkg::KIND_INSERT, pick_value(small_pct));
			else
				send_request(sapq_pkg::KIND_DELETE, $urandom());
		end
		no_idle = 1'b0;
		s_tvalid <= 1'b0;
	endtask

	// result sink with random stalls
	initial begin
		int stall;
		int burst;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			burst = $urandom_range(1, 8);
			repeat (burst - 1) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tuser, m_tdata);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		tracker = new;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		run_random();
		while (tracker.pending() != 0)
			@(posedge clk);
		// let any stray result show up
		repeat (40) @(posedge clk);
		if (tracker.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
